/* src/fcfs_process_scheduler_defines.svh */
// ----------------------------------------------------------------------------
// FCFS scheduler assertion macros
// Concurrent assertion wrappers; they expand to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef FCFS_PROCESS_SCHEDULER_DEFINES_SVH
`define FCFS_PROCESS_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
`define FCFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FCFS_NEVER(lbl, expr, msg) \
    `FCFS_ASSERT(lbl, !(expr), msg)
`else
`define FCFS_ASSERT(lbl, prop, msg)
`define FCFS_NEVER(lbl, expr, msg)
`endif
`endif

/* src/fcfs_pkg.sv */
// ----------------------------------------------------------------------------
// FCFS scheduler package
// Sizes, codes and the task table entry layout shared by the scheduler.
// ----------------------------------------------------------------------------
package fcfs_pkg;

    localparam int TASK_SLOTS = 16;
    localparam int SLOT_W     = $clog2(TASK_SLOTS);
    localparam int CNT_W      = SLOT_W + 1;

    typedef enum logic [1:0] {
        CMD_ADMIT = 2'd0,
        CMD_KILL  = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        PH_FREE  = 3'd0,
        PH_READY = 3'd1,
        PH_RUN   = 3'd2,
        PH_WAIT  = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

    typedef enum logic [3:0] {
        S_ADMITTED = 4'd0,
        S_DUP      = 4'd1,
        S_FULL     = 4'd2,
        S_KILLED   = 4'd3,
        S_KILL_IGN = 4'd4,
        S_IDLE     = 4'd5,
        S_RAN      = 4'd6,
        S_BLOCKED  = 4'd7,
        S_DONE     = 4'd8
    } status_t;

    typedef struct packed {
        logic [15:0]        id;
        logic [15:0]        burst;
        logic [15:0]        left;
        logic signed [16:0] io_at;
        logic [15:0]        io_len;
        logic [15:0]        io_left;
        logic [16:0]        done;
        phase_t             phase;
    } slot_t;

    localparam int SLOT_BITS = $bits(slot_t);

    typedef struct packed {
        logic              push;
        logic              pop;
        logic              drop;
        logic [SLOT_W-1:0] push_val;
        logic [SLOT_W-1:0] drop_val;
    } q_ctl_t;

endpackage

/* src/fcfs_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fcfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* src/fcfs_queue.sv */
// ----------------------------------------------------------------------------
// FCFS slot queue
// Ordered list of slot numbers: append at the tail, pop the head, or remove
// one matching entry and close the gap.
// ----------------------------------------------------------------------------
module fcfs_queue (
    input  logic                       clk,
    input  logic                       rst_n,
    input  fcfs_pkg::q_ctl_t           ctl,
    output logic [fcfs_pkg::SLOT_W-1:0] head,
    output logic [fcfs_pkg::CNT_W-1:0]  count
);
    import fcfs_pkg::*;

    logic [SLOT_W-1:0] q_reg [TASK_SLOTS];
    logic [SLOT_W-1:0] q_next [TASK_SLOTS];
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [CNT_W-1:0]  cnt_rem;
    logic              hit;
    logic              rem;
    logic [SLOT_W-1:0] pos;
    logic [SLOT_W-1:0] rpos;

    always_comb
    begin
        hit = 1'b0;
        pos = '0;
        for (int j = 0; j < TASK_SLOTS; j++)
        begin
            if (!hit && CNT_W'(j) < cnt_reg && q_reg[j] == ctl.drop_val)
            begin
                hit = 1'b1;
                pos = SLOT_W'(j);
            end
        end
        rem  = ctl.pop | (ctl.drop & hit);
        rpos = ctl.pop ? '0 : pos;
        q_next = q_reg;
        // close the gap behind the removed entry
        for (int j = 0; j < TASK_SLOTS - 1; j++)
        begin
            if (rem && SLOT_W'(j) >= rpos)
            begin
                q_next[j] = q_reg[j+1];
            end
        end
        cnt_rem = cnt_reg - CNT_W'(rem);
        if (ctl.push)
        begin
            q_next[cnt_rem[SLOT_W-1:0]] = ctl.push_val;
        end
        cnt_next = cnt_rem + CNT_W'(ctl.push);
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    assign head  = q_reg[0];
    assign count = cnt_reg;

endmodule

/* src/fcfs_process_scheduler.sv */
// ----------------------------------------------------------------------------
// FCFS process scheduler
// First-come-first-served task scheduler with I/O blocking and a bounded
// task table held in a synchronous RAM.
// ----------------------------------------------------------------------------
// One command transfer in, one result transfer out (cmd 3 is dropped with no
// result). The task table lives in one RAM with a registered read, so every
// table access is a read state and a check/write-back state. An admit or kill
// searches the occupied slots for the id. A tick walks the I/O wait list once
// and then updates the running task. The input is accepted only while the
// sequencer is idle; a finished result sits in the output register, so the
// next command may be taken while it waits for the sink. No clearing pass is
// needed after reset.
// ----------------------------------------------------------------------------
`include "fcfs_process_scheduler_defines.svh"

module fcfs_process_scheduler (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // task_id[15:0], burst_len[31:16], io_point[48:32], io_length[64:49], zero pad
    input  logic [71:0]  s_axis_tdata,
    // cmd[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_id[15:0], event_time[47:16], turnaround[79:48], waiting_time[111:80]
    output logic [111:0] m_axis_tdata,
    // status[3:0]
    output logic [3:0]   m_axis_tuser
);
    import fcfs_pkg::*;

    typedef enum logic [3:0] {
        IDLE, SCAN_RD, SCAN_CHK, DECIDE, TICK_DISP,
        IO_RD, IO_CHK, CPU_RD, CPU_CHK, FINISH
    } state_t;

    state_t             st_reg;
    cmd_t               cmd_reg;
    logic [15:0]        id_reg;
    logic [15:0]        burst_reg;
    logic signed [16:0] io_at_reg;
    logic [15:0]        io_len_reg;
    logic [31:0]        time_reg;
    logic [CNT_W-1:0]   used_reg;
    logic               cpu_busy_reg;
    logic [SLOT_W-1:0]  cpu_slot_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic               found_reg;
    logic [SLOT_W-1:0]  f_reg;
    slot_t              word_reg;
    logic [CNT_W-1:0]   io_cnt_reg;
    status_t            res_status_reg;
    logic [15:0]        res_id_reg;
    logic [31:0]        res_ev_reg;
    logic [31:0]        res_tat_reg;
    logic [31:0]        res_wt_reg;
    logic               out_valid_reg;
    logic [111:0]       out_data_reg;
    logic [3:0]         out_user_reg;

    // table RAM
    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr;
    slot_t              ram_wdata;
    logic [SLOT_W-1:0]  ram_raddr;
    logic [SLOT_BITS-1:0] ram_rbits;
    slot_t              rd;

    // queues
    q_ctl_t             rq_ctl;
    q_ctl_t             bq_ctl;
    logic [SLOT_W-1:0]  rq_head;
    logic [SLOT_W-1:0]  bq_head;
    logic [CNT_W-1:0]   rq_cnt;
    logic [CNT_W-1:0]   bq_cnt;

    // derived updates of the word just read
    slot_t              io_word;
    logic               io_zero;
    slot_t              cpu_word;
    logic               cpu_block;
    logic               cpu_done;
    slot_t              new_word;
    logic               in_xfer;
    logic               kill_cpu;
    logic               table_full;

    assign rd      = slot_t'(ram_rbits);
    assign in_xfer = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (st_reg == IDLE);
    assign kill_cpu   = cpu_busy_reg && (cpu_slot_reg == f_reg);
    assign table_full = (used_reg == CNT_W'(TASK_SLOTS));

    fcfs_ram #(
        .WIDTH (SLOT_BITS),
        .DEPTH (TASK_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rbits)
    );

    fcfs_queue u_ready (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (rq_ctl),
        .head  (rq_head),
        .count (rq_cnt)
    );

    fcfs_queue u_blocked (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (bq_ctl),
        .head  (bq_head),
        .count (bq_cnt)
    );

    // I/O countdown of a waiting task, the one-unit run of the CPU task and a new task's entry
    always_comb
    begin
        io_word = rd;
        if (rd.io_left != 16'd0)
        begin
            io_word.io_left = rd.io_left - 16'd1;
        end
        io_zero = (io_word.io_left == 16'd0);
        if (io_zero)
        begin
            io_word.phase = PH_READY;
        end

        cpu_word       = rd;
        cpu_word.phase = PH_RUN;
        cpu_word.done  = rd.done + 17'd1;
        if (rd.left != 16'd0)
        begin
            cpu_word.left = rd.left - 16'd1;
        end
        cpu_block = (cpu_word.left != 16'd0) && !rd.io_at[16]
                    && (cpu_word.done == rd.io_at) && (rd.io_len != 16'd0);
        cpu_done  = !cpu_block && (cpu_word.left == 16'd0);
        if (cpu_block)
        begin
            cpu_word.io_left = rd.io_len;
            cpu_word.phase   = PH_WAIT;
        end
        else if (cpu_done)
        begin
            cpu_word.phase = PH_DONE;
        end

        new_word.id      = id_reg;
        new_word.burst   = burst_reg;
        new_word.left    = burst_reg;
        new_word.io_at   = io_at_reg;
        new_word.io_len  = io_len_reg;
        new_word.io_left = 16'd0;
        new_word.done    = 17'd0;
        new_word.phase   = PH_READY;
    end

    // RAM and queue control, decoded from the sequencer state
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = f_reg;
        ram_wdata = word_reg;
        ram_raddr = idx_reg[SLOT_W-1:0];
        rq_ctl    = '0;
        bq_ctl    = '0;
        unique case (st_reg)
            IDLE, SCAN_RD, SCAN_CHK, FINISH:
            begin
                ram_raddr = idx_reg[SLOT_W-1:0];
            end
            DECIDE:
            begin
                ram_wdata.phase = PH_DONE;
                if (cmd_reg == CMD_ADMIT)
                begin
                    if (!found_reg && !table_full)
                    begin
                        ram_we          = 1'b1;
                        ram_waddr       = used_reg[SLOT_W-1:0];
                        ram_wdata       = new_word;
                        rq_ctl.push     = 1'b1;
                        rq_ctl.push_val = used_reg[SLOT_W-1:0];
                    end
                end
                else if (found_reg)
                begin
                    // kill: running, ready or waiting task ends
                    if (kill_cpu)
                    begin
                        ram_we = 1'b1;
                    end
                    else if (word_reg.phase == PH_READY)
                    begin
                        ram_we          = 1'b1;
                        rq_ctl.drop     = 1'b1;
                        rq_ctl.drop_val = f_reg;
                    end
                    else if (word_reg.phase == PH_WAIT)
                    begin
                        ram_we          = 1'b1;
                        bq_ctl.drop     = 1'b1;
                        bq_ctl.drop_val = f_reg;
                    end
                end
            end
            TICK_DISP:
            begin
                rq_ctl.pop = !cpu_busy_reg && (rq_cnt != '0);
            end
            IO_RD:
            begin
                ram_raddr = bq_head;
            end
            IO_CHK:
            begin
                // rotate the wait list: finished I/O goes to ready, the rest to the tail
                ram_we     = 1'b1;
                ram_waddr  = bq_head;
                ram_wdata  = io_word;
                bq_ctl.pop = 1'b1;
                if (io_zero)
                begin
                    rq_ctl.push     = 1'b1;
                    rq_ctl.push_val = bq_head;
                end
                else
                begin
                    bq_ctl.push     = 1'b1;
                    bq_ctl.push_val = bq_head;
                end
            end
            CPU_RD:
            begin
                ram_raddr = cpu_slot_reg;
            end
            CPU_CHK:
            begin
                ram_we          = 1'b1;
                ram_waddr       = cpu_slot_reg;
                ram_wdata       = cpu_word;
                bq_ctl.push     = cpu_block;
                bq_ctl.push_val = cpu_slot_reg;
            end
        endcase
    end

    // sequencer, scheduler registers and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg         <= IDLE;
            cmd_reg        <= CMD_NONE;
            time_reg       <= '0;
            used_reg       <= '0;
            cpu_busy_reg   <= 1'b0;
            cpu_slot_reg   <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            io_cnt_reg     <= '0;
            out_valid_reg  <= 1'b0;
            res_status_reg <= S_IDLE;
        end
        else
        begin
            // load a finished result when the output register is free
            if (st_reg == FINISH && (!out_valid_reg || m_axis_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (st_reg)
                IDLE:
                begin
                    if (in_xfer)
                    begin
                        cmd_reg     <= cmd_t'(s_axis_tuser);
                        id_reg      <= s_axis_tdata[15:0];
                        burst_reg   <= s_axis_tdata[31:16];
                        io_at_reg   <= s_axis_tdata[48:32];
                        io_len_reg  <= s_axis_tdata[64:49];
                        res_id_reg  <= (cmd_t'(s_axis_tuser) == CMD_TICK) ? 16'd0
                                                                          : s_axis_tdata[15:0];
                        res_ev_reg  <= time_reg;
                        res_tat_reg <= '0;
                        res_wt_reg  <= '0;
                        idx_reg     <= '0;
                        found_reg   <= 1'b0;
                        unique case (cmd_t'(s_axis_tuser))
                            CMD_ADMIT, CMD_KILL:
                            begin
                                st_reg <= SCAN_RD;
                            end
                            CMD_TICK:
                            begin
                                time_reg   <= time_reg + 32'd1;
                                st_reg     <= TICK_DISP;
                            end
                            CMD_NONE:
                            begin
                                st_reg <= IDLE;
                            end
                        endcase
                    end
                end
                SCAN_RD:
                begin
                    st_reg <= (idx_reg == used_reg) ? DECIDE : SCAN_CHK;
                end
                SCAN_CHK:
                begin
                    if (rd.id == id_reg)
                    begin
                        found_reg <= 1'b1;
                        f_reg     <= idx_reg[SLOT_W-1:0];
                        word_reg  <= rd;
                        st_reg    <= DECIDE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                        st_reg  <= SCAN_RD;
                    end
                end
                DECIDE:
                begin
                    if (cmd_reg == CMD_ADMIT)
                    begin
                        if (found_reg)
                        begin
                            res_status_reg <= S_DUP;
                        end
                        else if (table_full)
                        begin
                            res_status_reg <= S_FULL;
                        end
                        else
                        begin
                            res_status_reg <= S_ADMITTED;
                            used_reg       <= used_reg + CNT_W'(1);
                        end
                    end
                    else
                    begin
                        if (found_reg && (kill_cpu || word_reg.phase == PH_READY ||
                                          word_reg.phase == PH_WAIT))
                        begin
                            res_status_reg <= S_KILLED;
                        end
                        else
                        begin
                            res_status_reg <= S_KILL_IGN;
                        end
                        if (found_reg && kill_cpu)
                        begin
                            cpu_busy_reg <= 1'b0;
                        end
                    end
                    st_reg <= FINISH;
                end
                TICK_DISP:
                begin
                    // dispatch the ready head onto an idle CPU
                    if (!cpu_busy_reg && rq_cnt != '0)
                    begin
                        cpu_slot_reg <= rq_head;
                        cpu_busy_reg <= 1'b1;
                    end
                    io_cnt_reg <= bq_cnt;
                    st_reg     <= IO_RD;
                end
                IO_RD:
                begin
                    st_reg <= (io_cnt_reg == '0) ? CPU_RD : IO_CHK;
                end
                IO_CHK:
                begin
                    io_cnt_reg <= io_cnt_reg - CNT_W'(1);
                    st_reg     <= IO_RD;
                end
                CPU_RD:
                begin
                    if (cpu_busy_reg)
                    begin
                        st_reg <= CPU_CHK;
                    end
                    else
                    begin
                        res_status_reg <= S_IDLE;
                        st_reg         <= FINISH;
                    end
                end
                CPU_CHK:
                begin
                    res_id_reg <= rd.id;
                    if (cpu_block)
                    begin
                        cpu_busy_reg   <= 1'b0;
                        res_status_reg <= S_BLOCKED;
                    end
                    else if (cpu_done)
                    begin
                        cpu_busy_reg   <= 1'b0;
                        res_status_reg <= S_DONE;
                        res_ev_reg     <= res_ev_reg + 32'd1;
                        res_tat_reg    <= res_ev_reg + 32'd1;
                        res_wt_reg     <= res_ev_reg + 32'd1 - {16'd0, rd.burst};
                    end
                    else
                    begin
                        res_status_reg <= S_RAN;
                    end
                    st_reg <= FINISH;
                end
                FINISH:
                begin
                    // hold until the output register is free
                    if (!out_valid_reg || m_axis_tready)
                    begin
                        out_user_reg  <= res_status_reg;
                        out_data_reg  <= {res_wt_reg, res_tat_reg, res_ev_reg, res_id_reg};
                        st_reg        <= IDLE;
                    end
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    `FCFS_NEVER(a_queues_fit, (CNT_W+1)'(rq_cnt) + (CNT_W+1)'(bq_cnt) > (CNT_W+1)'(used_reg), "queues exceed table")
    `FCFS_NEVER(a_cpu_slot, cpu_busy_reg && (CNT_W'(cpu_slot_reg) >= used_reg), "CPU slot not occupied")
    `FCFS_ASSERT(a_idle_hold, (st_reg == IDLE && !s_axis_tvalid) |=> (st_reg == IDLE), "left idle with no command")

endmodule
